[design/nalsp_pkg.sv]
// Package for the Annex B NAL splitter: shared types and constants.
// Used by the front, the command queue, the back and the top level.
package nalsp_pkg;

    localparam logic [7:0] START_BYTE        = 8'h01;
    localparam logic [7:0] ZERO_BYTE         = 8'h00;
    localparam logic [1:0] ZERO_RUN_MAX      = 2'd3;
    localparam logic [1:0] ZERO_RUN_CODE     = 2'd2;
    localparam logic [2:0] PREFIX_LEN_SHORT  = 3'd3;
    localparam logic [2:0] PREFIX_LEN_LONG   = 3'd4;
    localparam logic [2:0] PREFIX_LEN_NONE   = 3'd0;

    // One command per transfer that releases bytes: optional held byte,
    // a run of held zeros, optional current byte, in stream order.
    typedef struct packed {
        logic [7:0] held_byte;
        logic [7:0] new_byte;
        logic       use_held;
        logic       use_new;
        logic [1:0] last_idx;
        logic       mark_last;
        logic       frame_end;
        logic       first;
        logic [2:0] prefix_len;
    } cmd_t;

endpackage

[design/nalsp_front.sv]
// Front of the NAL splitter: accepts stream bytes, tracks start codes and
// held bytes, and issues one release command per transfer. Uses nalsp_pkg.
module nalsp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    output logic                cmd_push,
    output nalsp_pkg::cmd_t     cmd
);
    import nalsp_pkg::*;

    logic       has_reg, has_next;
    logic [7:0] held_reg, held_next;
    logic [1:0] zr_reg, zr_next;
    logic       ins_reg, ins_next;
    logic       mark_reg, mark_next;
    logic [2:0] psl_reg, psl_next;

    logic       is_start;
    logic       is_zero;
    logic       use_held;
    logic       use_new;
    logic       mark_last;
    logic [1:0] nz;
    logic [2:0] count;

    assign is_start = (data_byte == START_BYTE) && (zr_reg >= ZERO_RUN_CODE);
    assign is_zero  = (data_byte == ZERO_BYTE);

    // Classify the byte: which held bytes and which current byte go out.
    always_comb
    begin
        use_held  = 1'b0;
        use_new   = 1'b0;
        nz        = 2'd0;
        mark_last = 1'b0;
        if (is_start)
        begin
            use_held  = ins_reg && has_reg;
            mark_last = 1'b1;
        end
        else if (is_zero)
        begin
            if (ins_reg)
            begin
                if (zr_reg >= ZERO_RUN_CODE)
                begin
                    use_held  = has_reg;
                    mark_last = 1'b1;
                end
                else if (frame_last)
                begin
                    use_held  = has_reg;
                    nz        = zr_reg + 2'd1;
                    mark_last = 1'b1;
                end
            end
        end
        else if (ins_reg)
        begin
            use_held  = has_reg;
            nz        = zr_reg;
            use_new   = frame_last;
            mark_last = frame_last;
        end
    end

    assign count    = {2'b00, use_held} + {1'b0, nz} + {2'b00, use_new};
    assign cmd_push = accept && (count != 3'd0);

    always_comb
    begin
        cmd            = '0;
        cmd.held_byte  = held_reg;
        cmd.new_byte   = data_byte;
        cmd.use_held   = use_held;
        cmd.use_new    = use_new;
        cmd.last_idx   = 2'(count - 3'd1);
        cmd.mark_last  = mark_last;
        cmd.frame_end  = frame_last;
        cmd.first      = mark_reg;
        cmd.prefix_len = psl_reg;
    end

    always_comb
    begin
        has_next  = has_reg;
        held_next = held_reg;
        zr_next   = zr_reg;
        ins_next  = ins_reg;
        psl_next  = psl_reg;
        mark_next = (count != 3'd0) ? 1'b0 : mark_reg;
        if (is_start)
        begin
            psl_next  = (zr_reg == ZERO_RUN_MAX) ? PREFIX_LEN_LONG : PREFIX_LEN_SHORT;
            ins_next  = 1'b1;
            mark_next = 1'b1;
            has_next  = 1'b0;
            zr_next   = 2'd0;
        end
        else if (is_zero)
        begin
            if (ins_reg)
            begin
                if (zr_reg >= ZERO_RUN_CODE)
                begin
                    ins_next  = 1'b0;
                    mark_next = 1'b0;
                    has_next  = 1'b0;
                    zr_next   = ZERO_RUN_MAX;
                end
                else
                begin
                    zr_next = zr_reg + 2'd1;
                end
            end
            else if (zr_reg != ZERO_RUN_MAX)
            begin
                zr_next = zr_reg + 2'd1;
            end
        end
        else
        begin
            if (ins_reg)
            begin
                has_next  = 1'b1;
                held_next = data_byte;
            end
            zr_next = 2'd0;
        end
        // Clear on frame end
        if (frame_last)
        begin
            has_next  = 1'b0;
            zr_next   = 2'd0;
            ins_next  = 1'b0;
            mark_next = 1'b0;
            psl_next  = PREFIX_LEN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg  <= 1'b0;
            zr_reg   <= 2'd0;
            ins_reg  <= 1'b0;
            mark_reg <= 1'b0;
            psl_reg  <= PREFIX_LEN_NONE;
        end
        else if (accept)
        begin
            has_reg  <= has_next;
            zr_reg   <= zr_next;
            ins_reg  <= ins_next;
            mark_reg <= mark_next;
            psl_reg  <= psl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

[design/nalsp_queue.sv]
// Command queue between front and back of the NAL splitter.
// Small register FIFO of nalsp_pkg::cmd_t entries.
module nalsp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nalsp_pkg::cmd_t     wr_data,
    input  logic                pop,
    output nalsp_pkg::cmd_t     rd_data,
    output logic                full,
    output logic                not_empty
);
    import nalsp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/nalsp_back.sv]
// Back of the NAL splitter: expands each release command into NAL bytes,
// one per cycle while nal_stall is low, into the output register. Uses nalsp_pkg.
module nalsp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  nalsp_pkg::cmd_t     cmd,
    output logic                cmd_pop,
    input  logic                nal_stall,
    output logic                nal_valid,
    output logic [7:0]          nal_byte,
    output logic                nal_first,
    output logic                nal_last,
    output logic [5:0]          nal_kind,
    output logic [2:0]          prefix_len,
    output logic                frame_end
);
    import nalsp_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       last_reg;
    logic [5:0] kind_reg;
    logic [2:0] len_reg;
    logic       fend_reg;

    logic       load;
    logic       at_end;
    logic       at_first;
    logic [7:0] beat_byte;

    assign load     = cmd_valid && (!valid_reg || !nal_stall);
    assign at_end   = (idx_reg == cmd.last_idx);
    assign at_first = (idx_reg == 2'd0);
    assign cmd_pop  = load && at_end;

    always_comb
    begin
        if (at_first && cmd.use_held)
        begin
            beat_byte = cmd.held_byte;
        end
        else if (at_end && cmd.use_new)
        begin
            beat_byte = cmd.new_byte;
        end
        else
        begin
            beat_byte = ZERO_BYTE;
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_end ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (!nal_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= beat_byte;
            first_reg <= at_first && cmd.first;
            last_reg  <= at_end && cmd.mark_last;
            fend_reg  <= at_end && cmd.frame_end;
            kind_reg  <= (at_first && cmd.first) ? beat_byte[6:1] : 6'd0;
            len_reg   <= (at_first && cmd.first) ? cmd.prefix_len : PREFIX_LEN_NONE;
        end
    end

    assign nal_valid  = valid_reg;
    assign nal_byte   = byte_reg;
    assign nal_first  = first_reg;
    assign nal_last   = last_reg;
    assign nal_kind   = kind_reg;
    assign prefix_len = len_reg;
    assign frame_end  = fend_reg;

endmodule

[design/annexb_nal_splitter.sv]
// Top level of the Annex B NAL splitter: front, command queue and back.
// Depends on nalsp_pkg, nalsp_front, nalsp_queue and nalsp_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   input   | byte_valid, byte_stall  | data_byte, frame_last
//   output  | nal_valid, nal_stall    | nal_byte, nal_first, nal_last,
//           |                         | nal_kind, prefix_len, frame_end
//
// One input byte is taken per cycle while the command queue has room.
// A byte that releases held bytes queues one command; the back turns it
// into one to four output bytes at one byte per cycle while nal_stall is low.
// Commands are registered in the queue, and output bytes in the output register.
// Reset is asynchronous, active low, and clears all control state.
// byte_stall rises when the queue is full; nal_stall holds the output register.
module annexb_nal_splitter
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    output logic        nal_valid,
    input  logic        nal_stall,
    output logic [7:0]  nal_byte,
    output logic        nal_first,
    output logic        nal_last,
    output logic [5:0]  nal_kind,
    output logic [2:0]  prefix_len,
    output logic        frame_end
);
    import nalsp_pkg::*;

    logic  accept;
    logic  cmd_push;
    logic  cmd_pop;
    logic  q_full;
    logic  q_not_empty;
    cmd_t  cmd_in;
    cmd_t  cmd_out;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !byte_stall;

    nalsp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .frame_last (frame_last),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    nalsp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .wr_data   (cmd_in),
        .pop       (cmd_pop),
        .rd_data   (cmd_out),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    nalsp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_not_empty),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .nal_stall  (nal_stall),
        .nal_valid  (nal_valid),
        .nal_byte   (nal_byte),
        .nal_first  (nal_first),
        .nal_last   (nal_last),
        .nal_kind   (nal_kind),
        .prefix_len (prefix_len),
        .frame_end  (frame_end)
    );

endmodule

[design/nalsp_checker.sv]
// Port-level checker for the Annex B NAL splitter, bound to the top level.
// Sees only the ports of annexb_nal_splitter.
module nalsp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  data_byte,
    input logic        frame_last,
    input logic        nal_valid,
    input logic        nal_stall,
    input logic [7:0]  nal_byte,
    input logic        nal_first,
    input logic        nal_last,
    input logic [5:0]  nal_kind,
    input logic [2:0]  prefix_len,
    input logic        frame_end
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(data_byte) && $stable(frame_last))
        else $error("input transfer changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nal_valid && nal_stall |=> nal_valid && $stable(nal_byte) && $stable(nal_last))
        else $error("output transfer changed while stalled");

    a_first_fields: assert property (@(posedge clk) disable iff (!rst_n)
        nal_valid && nal_first |->
            (prefix_len == 3'd3 || prefix_len == 3'd4) && nal_kind == nal_byte[6:1])
        else $error("first byte with bad start code length or NAL type");

    a_rest_clear: assert property (@(posedge clk) disable iff (!rst_n)
        nal_valid && !nal_first |-> prefix_len == 3'd0 && nal_kind == 6'd0)
        else $error("type or length set on a non-first byte");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        nal_valid && frame_end |-> nal_last)
        else $error("frame end on a byte that does not close its NAL");

endmodule

bind annexb_nal_splitter nalsp_checker u_nalsp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .frame_last (frame_last),
    .nal_valid  (nal_valid),
    .nal_stall  (nal_stall),
    .nal_byte   (nal_byte),
    .nal_first  (nal_first),
    .nal_last   (nal_last),
    .nal_kind   (nal_kind),
    .prefix_len (prefix_len),
    .frame_end  (frame_end)
);
